@@ sv/fpr_pkg.sv @@
// Package for the framed packet receiver: parser phases, status codes,
// framing constants, the result record and the CRC-16/CCITT-FALSE byte step.
// No dependencies.
package fpr_pkg;

  localparam logic [7:0]  SOF_BYTE = 8'h02;
  localparam logic [7:0]  EOF_BYTE = 8'h03;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  TYPE_LIMIT_RESET = 8'd16;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TYPE = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_CRCH = 3'd4,
    PH_CRCL = 3'd5,
    PH_TAIL = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_GOOD      = 3'd1,
    ST_BAD_START = 3'd2,
    ST_BAD_TYPE  = 3'd3,
    ST_CRC_FAIL  = 3'd4,
    ST_BAD_END   = 3'd5
  } status_t;

  typedef struct packed {
    status_t    status;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ sv/fpr_frame_fsm.sv @@
// Frame parser state machine: phase, running CRC, held type and length and
// the payload byte count, with the result for the word being taken.
// Depends on fpr_pkg.
module fpr_frame_fsm
  import fpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  input  logic [7:0] type_limit,
  output phase_t     phase,
  output result_t    result
);

  phase_t      phase_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  held_type, held_type_next;
  logic [7:0]  held_length, held_length_next;
  logic [7:0]  bytes_seen, bytes_seen_next;
  logic [15:0] crc_step;
  status_t     status_w;
  logic        pv_w;
  logic [7:0]  pb_w;

  assign crc_step = crc_feed(running_crc, rx_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      running_crc <= CRC_INIT;
      held_type   <= 8'd0;
      held_length <= 8'd0;
      bytes_seen  <= 8'd0;
    end else if (take) begin
      phase       <= phase_next;
      running_crc <= running_crc_next;
      held_type   <= held_type_next;
      held_length <= held_length_next;
      bytes_seen  <= bytes_seen_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    running_crc_next = running_crc;
    held_type_next   = held_type;
    held_length_next = held_length;
    bytes_seen_next  = bytes_seen;
    status_w         = ST_BUSY;
    pv_w             = 1'b0;
    pb_w             = 8'd0;
    case (phase)
      PH_TYPE: begin
        if (rx_byte >= type_limit) begin
          status_w   = ST_BAD_TYPE;
          phase_next = PH_IDLE;
        end else begin
          running_crc_next = crc_step;
          held_type_next   = rx_byte;
          phase_next       = PH_LEN;
        end
      end
      PH_LEN: begin
        running_crc_next = crc_step;
        held_length_next = rx_byte;
        bytes_seen_next  = 8'd0;
        phase_next       = (rx_byte == 8'd0) ? PH_CRCH : PH_DATA;
      end
      PH_DATA: begin
        pv_w             = 1'b1;
        pb_w             = rx_byte;
        running_crc_next = crc_step;
        bytes_seen_next  = bytes_seen + 8'd1;
        if (bytes_seen_next >= held_length) begin
          phase_next = PH_CRCH;
        end
      end
      PH_CRCH: begin
        running_crc_next = crc_step;
        phase_next       = PH_CRCL;
      end
      PH_CRCL: begin
        running_crc_next = crc_step;
        if (crc_step != 16'd0) begin
          status_w   = ST_CRC_FAIL;
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_TAIL;
        end
      end
      PH_TAIL: begin
        status_w   = (rx_byte == EOF_BYTE) ? ST_GOOD : ST_BAD_END;
        phase_next = PH_IDLE;
      end
      default: begin
        if (rx_byte != SOF_BYTE) begin
          status_w   = ST_BAD_START;
          phase_next = PH_IDLE;
        end else begin
          running_crc_next = CRC_INIT;
          held_type_next   = 8'd0;
          held_length_next = 8'd0;
          bytes_seen_next  = 8'd0;
          phase_next       = PH_TYPE;
        end
      end
    endcase
  end

  always_comb begin
    result.status        = status_w;
    result.payload_valid = pv_w;
    result.payload_byte  = pb_w;
    result.frame_type    = held_type_next;
    result.frame_length  = held_length_next;
  end

endmodule

@@ sv/framed_packet_receiver_crc16.sv @@
// Framed packet receiver with CRC-16/CCITT-FALSE check; top level.
// The result for an accepted word is registered in the output register.
// Throughput: one word per cycle; the single output register stalls input only while
// a result waits and the output is stalled.
// Reset (rst, synchronous): parser idle, CRC 0xFFFF, held fields zero, type_limit 16.
// Depends on fpr_pkg and fpr_frame_fsm.
module framed_packet_receiver_crc16
  import fpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic       payload_valid,
  output logic [7:0] payload_byte,
  output logic [7:0] frame_type,
  output logic [7:0] frame_length
);

  logic [7:0] type_limit;
  logic       in_accept;
  logic       out_valid_next;
  phase_t     phase;
  result_t    result;
  result_t    out_reg;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_limit <= TYPE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      type_limit <= cfg_data;
    end
  end

  fpr_frame_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .take       (in_accept),
    .rx_byte    (rx_byte),
    .type_limit (type_limit),
    .phase      (phase),
    .result     (result)
  );

  assign out_valid_next = in_accept | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_reg <= result;
    end
  end

  assign status        = out_reg.status;
  assign payload_valid = out_reg.payload_valid;
  assign payload_byte  = out_reg.payload_byte;
  assign frame_type    = out_reg.frame_type;
  assign frame_length  = out_reg.frame_length;

  a_payload_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_valid |-> status == ST_BUSY)
    else $error("payload word carries a final status");

  a_tail_to_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept && phase == PH_TAIL |=> phase == PH_IDLE && out_valid && status != ST_BUSY)
    else $error("end position did not close the frame");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && phase == PH_IDLE && rx_byte == SOF_BYTE |=>
      phase == PH_TYPE && frame_type == 8'd0 && frame_length == 8'd0 && status == ST_BUSY)
    else $error("start word did not open a clean frame");

  a_bad_start: assert property (@(posedge clk) disable iff (rst)
    in_accept && phase == PH_IDLE && rx_byte != SOF_BYTE |=>
      phase == PH_IDLE && status == ST_BAD_START)
    else $error("stray word while idle not reported");

endmodule
